[design/nbge_pkg.sv]
// Package: shared types, constants and arithmetic helpers of the N-body Euler step unit.
`timescale 1ns / 1ps
package nbge_pkg;

  localparam int MAX_BODIES_DEF = 16;

  // Configuration port.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_W    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_H    = 2'd3;

  localparam logic [31:0] GRAVITY_RST   = 32'd65536;
  localparam logic [31:0] TIME_STEP_RST = 32'd1092;
  localparam logic [15:0] AREA_W_RST    = 16'd800;
  localparam logic [15:0] AREA_H_RST    = 16'd600;

  // Input opcodes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam int OUT_IDX_W = 4;

  // pi in Q16.16.
  localparam logic [17:0] PI_Q16 = 18'd205887;

  // Saturation limits.
  localparam logic [61:0] ACC_LIM  = 62'(1) << 61;
  localparam logic [40:0] TERM_LIM = 41'(1) << 40;
  localparam logic signed [63:0] ACC_POS = 64'sd2305843009213693952;
  localparam logic signed [63:0] ACC_NEG = -64'sd2305843009213693952;
  localparam logic signed [43:0] S32_MAX = 44'sd2147483647;
  localparam logic signed [43:0] S32_MIN = -44'sd2147483648;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic         start;
    alu_op_t      op;
    logic [95:0]  a;
    logic [63:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [23:0]        radius;
    logic [47:0]        mass;
  } body_t;

  // Unsigned saturation of a quotient at the acceleration limit.
  function automatic logic [61:0] cap_acc(logic [95:0] v);
    return (v > 96'(ACC_LIM)) ? ACC_LIM : v[61:0];
  endfunction

  // Adds a signed term to an acceleration sum and clamps it to +-2^61.
  function automatic logic signed [63:0] acc_add(logic signed [63:0] acc, logic neg,
                                                  logic [61:0] t);
    logic signed [63:0] s;
    logic signed [63:0] sum;
    s   = neg ? -$signed({2'b00, t}) : $signed({2'b00, t});
    sum = acc + s;
    if (sum > ACC_POS) return ACC_POS;
    if (sum < ACC_NEG) return ACC_NEG;
    return sum;
  endfunction

  // One Euler update: value + sign * min((|mult| * dt) >> 16, 2^40), saturated.
  function automatic logic signed [31:0] euler_upd(logic signed [31:0] value, logic neg,
                                                   logic [127:0] prod);
    logic [111:0]       sh;
    logic [40:0]        t;
    logic signed [43:0] s;
    logic signed [43:0] sum;
    sh  = prod[127:16];
    t   = (sh > 112'(TERM_LIM)) ? TERM_LIM : sh[40:0];
    s   = neg ? -$signed({3'b000, t}) : $signed({3'b000, t});
    sum = $signed({{12{value[31]}}, value}) + s;
    if (sum > S32_MAX) return 32'sh7FFFFFFF;
    if (sum < S32_MIN) return 32'sh80000000;
    return sum[31:0];
  endfunction

endpackage

[design/nbge_if.sv]
// Interfaces: input and result channels of the N-body Euler step unit.
`timescale 1ns / 1ps
interface nbge_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] pos_x_in;
  logic signed [31:0] pos_y_in;
  logic [23:0]        radius_in;
  logic signed [31:0] vel_x_in;
  logic signed [31:0] vel_y_in;

  modport source (output valid, opcode, pos_x_in, pos_y_in, radius_in, vel_x_in, vel_y_in,
                  input ready);
  modport sink (input valid, opcode, pos_x_in, pos_y_in, radius_in, vel_x_in, vel_y_in,
                output ready);
endinterface

interface nbge_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         body_index;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic               last;

  modport source (output valid, body_index, pos_x_out, pos_y_out, last, input ready);
  modport sink (input valid, body_index, pos_x_out, pos_y_out, last, output ready);
endinterface

[design/nbody_gravity_euler_step_unit.sv]
// Top level: body table, tick sequencer and result channel of the N-body Euler step unit.
//
//   Port group  Dir  Handshake         Carries
//   in_ch       in   valid / ready     opcode, new body position, radius, velocity
//   out_ch      out  valid / ready     slot index, updated position, last flag
//   cfg_*       in   cfg_we (no wait)  G, time step, area width and height
//
// An insert appends the new body; when the table is full the oldest body is
// dropped first and the later slots move down. A tick works through every
// ordered pair of bodies on the shared arithmetic unit (four 96-step divisions,
// a 34-step square root and five 4-step multiplies per pair); each removal
// moves the later slots down, and output stalls hold each reported body.
// Reset clears the body count and restores the configuration defaults; the
// table is not cleared.
// in_ch.ready is high only while the block is idle; out_ch stalls hold the sequencer.
`timescale 1ns / 1ps
module nbody_gravity_euler_step_unit #(
  parameter int MAX_BODIES = nbge_pkg::MAX_BODIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  nbge_in_if.sink                         in_ch,
  nbge_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [nbge_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nbge_pkg::CFG_W-1:0]      cfg_wdata
);
  import nbge_pkg::*;

  localparam int IDX_W = $clog2(MAX_BODIES);
  localparam int CNT_W = $clog2(MAX_BODIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BODIES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_ALU_WAIT,
    ST_SW_RD,
    ST_SW_WR,
    ST_INS_SQ,
    ST_INS_PI,
    ST_INS_WR,
    ST_T_LOOP,
    ST_T_CHK,
    ST_P_LOOP,
    ST_P_DIFF,
    ST_P_SQX,
    ST_P_SQY,
    ST_P_SQRT,
    ST_P_OVL,
    ST_P_DIV1,
    ST_P_DIV2,
    ST_P_FX,
    ST_P_TXD,
    ST_P_FY,
    ST_P_TYD,
    ST_P_ACC,
    ST_E_VX,
    ST_E_VY,
    ST_E_PX,
    ST_E_PY,
    ST_E_WR,
    ST_O_RD,
    ST_O_LD,
    ST_O_SEND
  } state_t;

  // Configuration registers.
  logic [31:0] gravity_r;
  logic [31:0] dt_r;
  logic [15:0] area_w_r;
  logic [15:0] area_h_r;

  // Sequencer state and loop counters.
  state_t           state_r;
  state_t           after_r;   // where a memory read or an arithmetic call returns
  state_t           sw_ret_r;  // where a compaction sweep returns
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] j_r;
  logic [CNT_W-1:0] o_r;

  // Working registers.
  body_t              ins_r;
  body_t              cur_r;
  logic signed [63:0] ax_r;
  logic signed [63:0] ay_r;
  logic [32:0]        ux_r;
  logic [32:0]        uy_r;
  logic               sx_r;
  logic               sy_r;
  logic [66:0]        sq_r;
  logic [33:0]        d_r;
  logic [61:0]        f_r;

  // Output register.
  logic               out_valid_r;
  logic [3:0]         out_idx_r;
  logic signed [31:0] out_px_r;
  logic signed [31:0] out_py_r;
  logic               out_last_r;

  // Body table: one read port with registered data, one write port.
  body_t            mem [MAX_BODIES];
  logic [IDX_W-1:0] rd_addr_r;
  body_t            mem_q_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  body_t            mem_wd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic               in_fire;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [66:0]        sq_sum;
  logic [24:0]        r_sum;
  logic               pair_skip;
  logic [61:0]        q_cap;
  logic [63:0]        amag_x;
  logic [63:0]        amag_y;
  logic [32:0]        vmag_x;
  logic [32:0]        vmag_y;
  logic signed [35:0] q_x;
  logic signed [35:0] q_y;
  logic signed [35:0] q_r;
  logic signed [35:0] lim_x;
  logic signed [35:0] lim_y;
  logic               is_outside;
  logic [CNT_W-1:0]   jm1;

  nbge_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.body_index = out_idx_r;
  assign out_ch.pos_x_out  = out_px_r;
  assign out_ch.pos_y_out  = out_py_r;
  assign out_ch.last       = out_last_r;

  // Pair geometry: the other body comes from the table read, this body from cur_r.
  assign dx     = $signed({mem_q_r.pos_x[31], mem_q_r.pos_x}) -
                  $signed({cur_r.pos_x[31], cur_r.pos_x});
  assign dy     = $signed({mem_q_r.pos_y[31], mem_q_r.pos_y}) -
                  $signed({cur_r.pos_y[31], cur_r.pos_y});
  assign sq_sum = sq_r + {1'b0, alu_rsp.res[65:0]};
  assign r_sum  = {1'b0, cur_r.radius} + {1'b0, mem_q_r.radius};
  // Overlapping or coincident bodies exert no pull on each other.
  assign pair_skip = (alu_rsp.res[33:0] == 34'd0) ||
                     (alu_rsp.res[33:0] < {9'd0, r_sum});
  assign q_cap  = cap_acc(alu_rsp.res[95:0]);
  assign amag_x = ax_r[63] ? 64'(-ax_r) : 64'(ax_r);
  assign amag_y = ay_r[63] ? 64'(-ay_r) : 64'(ay_r);
  assign vmag_x = cur_r.vel_x[31] ? 33'(-$signed({1'b1, cur_r.vel_x})) : {1'b0, cur_r.vel_x};
  assign vmag_y = cur_r.vel_y[31] ? 33'(-$signed({1'b1, cur_r.vel_y})) : {1'b0, cur_r.vel_y};

  // A body is dropped once its whole disc lies beyond an edge of the area.
  assign q_x   = {{4{mem_q_r.pos_x[31]}}, mem_q_r.pos_x};
  assign q_y   = {{4{mem_q_r.pos_y[31]}}, mem_q_r.pos_y};
  assign q_r   = {12'd0, mem_q_r.radius};
  assign lim_x = $signed({4'd0, area_w_r, 16'd0}) + q_r;
  assign lim_y = $signed({4'd0, area_h_r, 16'd0}) + q_r;
  assign is_outside = (q_x > lim_x) || (q_x < -q_r) || (q_y > lim_y) || (q_y < -q_r);

  assign jm1 = j_r - CNT_ONE;

  // Arithmetic unit requests, one per calling state.
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      ST_INS_SQ: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(ins_r.radius);
        alu_req.b     = 64'(ins_r.radius);
      end
      ST_INS_PI: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(alu_rsp.res[47:16]);
        alu_req.b     = 64'(PI_Q16);
      end
      ST_P_SQX: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(ux_r);
        alu_req.b     = 64'(ux_r);
      end
      ST_P_SQY: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(uy_r);
        alu_req.b     = 64'(uy_r);
      end
      ST_P_SQRT: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_SQRT;
        alu_req.a     = 96'(sq_sum);
      end
      ST_P_OVL: begin
        alu_req.start = !pair_skip;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(gravity_r);
        alu_req.b     = 64'(mem_q_r.mass);
      end
      ST_P_DIV1: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_req.a     = {alu_rsp.res[79:0], 16'd0};
        alu_req.b     = 64'(d_r);
      end
      ST_P_DIV2, ST_P_TXD, ST_P_TYD: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_req.a     = alu_rsp.res[95:0];
        alu_req.b     = 64'(d_r);
      end
      ST_P_FX: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(q_cap);
        alu_req.b     = 64'(ux_r);
      end
      ST_P_FY: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(f_r);
        alu_req.b     = 64'(uy_r);
      end
      ST_E_VX: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(amag_x);
        alu_req.b     = 64'(dt_r);
      end
      ST_E_VY: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(amag_y);
        alu_req.b     = 64'(dt_r);
      end
      ST_E_PX: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(vmag_x);
        alu_req.b     = 64'(dt_r);
      end
      ST_E_PY: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 96'(vmag_y);
        alu_req.b     = 64'(dt_r);
      end
      default: alu_req = '0;
    endcase
  end

  // Table writes: compaction moves, inserts and the write-back of an updated body.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = mem_q_r;
    unique case (state_r)
      ST_SW_WR: begin
        mem_we = 1'b1;
        mem_wa = jm1[IDX_W-1:0];
        mem_wd = mem_q_r;
      end
      ST_INS_WR: begin
        mem_we      = 1'b1;
        mem_wa      = count_r[IDX_W-1:0];
        mem_wd      = ins_r;
        mem_wd.mass = alu_rsp.res[63:16];
      end
      ST_E_WR: begin
        mem_we       = 1'b1;
        mem_wa       = i_r[IDX_W-1:0];
        mem_wd       = cur_r;
        mem_wd.pos_y = euler_upd(cur_r.pos_y, cur_r.vel_y[31], alu_rsp.res);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= GRAVITY_RST;
      dt_r      <= TIME_STEP_RST;
      area_w_r  <= AREA_W_RST;
      area_h_r  <= AREA_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAVITY:   gravity_r <= cfg_wdata;
        CFG_TIME_STEP: dt_r      <= cfg_wdata;
        CFG_AREA_W:    area_w_r  <= cfg_wdata[15:0];
        CFG_AREA_H:    area_h_r  <= cfg_wdata[15:0];
        default:       gravity_r <= gravity_r;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      after_r     <= ST_IDLE;
      sw_ret_r    <= ST_IDLE;
      count_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      o_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            ins_r.pos_x  <= in_ch.pos_x_in;
            ins_r.pos_y  <= in_ch.pos_y_in;
            ins_r.vel_x  <= in_ch.vel_x_in;
            ins_r.vel_y  <= in_ch.vel_y_in;
            ins_r.radius <= in_ch.radius_in;
            ins_r.mass   <= '0;
            if (in_ch.opcode == OP_TICK) begin
              i_r     <= '0;
              state_r <= ST_T_LOOP;
            end else if (count_r == CNT_MAX) begin
              // Full table: drop the oldest body before appending.
              j_r      <= CNT_ONE;
              sw_ret_r <= ST_INS_SQ;
              state_r  <= ST_SW_RD;
            end else begin
              state_r <= ST_INS_SQ;
            end
          end
        end
        ST_RD_WAIT: begin
          state_r <= after_r;
        end
        ST_ALU_WAIT: begin
          if (alu_rsp.done) begin
            state_r <= after_r;
          end
        end
        ST_SW_RD: begin
          if (j_r >= count_r) begin
            count_r <= count_r - CNT_ONE;
            state_r <= sw_ret_r;
          end else begin
            rd_addr_r <= j_r[IDX_W-1:0];
            after_r   <= ST_SW_WR;
            state_r   <= ST_RD_WAIT;
          end
        end
        ST_SW_WR: begin
          j_r     <= j_r + CNT_ONE;
          state_r <= ST_SW_RD;
        end
        ST_INS_SQ: begin
          after_r <= ST_INS_PI;
          state_r <= ST_ALU_WAIT;
        end
        ST_INS_PI: begin
          after_r <= ST_INS_WR;
          state_r <= ST_ALU_WAIT;
        end
        ST_INS_WR: begin
          count_r <= count_r + CNT_ONE;
          state_r <= ST_IDLE;
        end
        ST_T_LOOP: begin
          if (i_r == count_r) begin
            o_r     <= '0;
            state_r <= (count_r == '0) ? ST_IDLE : ST_O_RD;
          end else begin
            rd_addr_r <= i_r[IDX_W-1:0];
            after_r   <= ST_T_CHK;
            state_r   <= ST_RD_WAIT;
          end
        end
        ST_T_CHK: begin
          cur_r <= mem_q_r;
          if (is_outside) begin
            // The next body slides into this slot and is visited next.
            j_r      <= i_r + CNT_ONE;
            sw_ret_r <= ST_T_LOOP;
            state_r  <= ST_SW_RD;
          end else begin
            ax_r    <= '0;
            ay_r    <= '0;
            j_r     <= '0;
            state_r <= ST_P_LOOP;
          end
        end
        ST_P_LOOP: begin
          if (j_r == count_r) begin
            state_r <= ST_E_VX;
          end else if (j_r == i_r) begin
            j_r <= j_r + CNT_ONE;
          end else begin
            rd_addr_r <= j_r[IDX_W-1:0];
            after_r   <= ST_P_DIFF;
            state_r   <= ST_RD_WAIT;
          end
        end
        ST_P_DIFF: begin
          sx_r    <= dx[32];
          sy_r    <= dy[32];
          ux_r    <= dx[32] ? 33'(-dx) : 33'(dx);
          uy_r    <= dy[32] ? 33'(-dy) : 33'(dy);
          state_r <= ST_P_SQX;
        end
        ST_P_SQX: begin
          after_r <= ST_P_SQY;
          state_r <= ST_ALU_WAIT;
        end
        ST_P_SQY: begin
          sq_r    <= {1'b0, alu_rsp.res[65:0]};
          after_r <= ST_P_SQRT;
          state_r <= ST_ALU_WAIT;
        end
        ST_P_SQRT: begin
          after_r <= ST_P_OVL;
          state_r <= ST_ALU_WAIT;
        end
        ST_P_OVL: begin
          d_r <= alu_rsp.res[33:0];
          if (pair_skip) begin
            j_r     <= j_r + CNT_ONE;
            state_r <= ST_P_LOOP;
          end else begin
            after_r <= ST_P_DIV1;
            state_r <= ST_ALU_WAIT;
          end
        end
        ST_P_DIV1: begin
          after_r <= ST_P_DIV2;
          state_r <= ST_ALU_WAIT;
        end
        ST_P_DIV2: begin
          after_r <= ST_P_FX;
          state_r <= ST_ALU_WAIT;
        end
        ST_P_FX: begin
          f_r     <= q_cap;
          after_r <= ST_P_TXD;
          state_r <= ST_ALU_WAIT;
        end
        ST_P_TXD: begin
          after_r <= ST_P_FY;
          state_r <= ST_ALU_WAIT;
        end
        ST_P_FY: begin
          ax_r    <= acc_add(ax_r, sx_r, q_cap);
          after_r <= ST_P_TYD;
          state_r <= ST_ALU_WAIT;
        end
        ST_P_TYD: begin
          after_r <= ST_P_ACC;
          state_r <= ST_ALU_WAIT;
        end
        ST_P_ACC: begin
          ay_r    <= acc_add(ay_r, sy_r, q_cap);
          j_r     <= j_r + CNT_ONE;
          state_r <= ST_P_LOOP;
        end
        ST_E_VX: begin
          after_r <= ST_E_VY;
          state_r <= ST_ALU_WAIT;
        end
        ST_E_VY: begin
          cur_r.vel_x <= euler_upd(cur_r.vel_x, ax_r[63], alu_rsp.res);
          after_r     <= ST_E_PX;
          state_r     <= ST_ALU_WAIT;
        end
        ST_E_PX: begin
          cur_r.vel_y <= euler_upd(cur_r.vel_y, ay_r[63], alu_rsp.res);
          after_r     <= ST_E_PY;
          state_r     <= ST_ALU_WAIT;
        end
        ST_E_PY: begin
          cur_r.pos_x <= euler_upd(cur_r.pos_x, cur_r.vel_x[31], alu_rsp.res);
          after_r     <= ST_E_WR;
          state_r     <= ST_ALU_WAIT;
        end
        ST_E_WR: begin
          i_r     <= i_r + CNT_ONE;
          state_r <= ST_T_LOOP;
        end
        ST_O_RD: begin
          rd_addr_r <= o_r[IDX_W-1:0];
          after_r   <= ST_O_LD;
          state_r   <= ST_RD_WAIT;
        end
        ST_O_LD: begin
          out_valid_r <= 1'b1;
          out_idx_r   <= OUT_IDX_W'(o_r);
          out_px_r    <= mem_q_r.pos_x;
          out_py_r    <= mem_q_r.pos_y;
          out_last_r  <= (o_r + CNT_ONE == count_r);
          state_r     <= ST_O_SEND;
        end
        ST_O_SEND: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            o_r         <= o_r + CNT_ONE;
            state_r     <= out_last_r ? ST_IDLE : ST_O_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // The body count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("body count exceeds table depth");

  // No new transaction is taken while a result is on offer.
  a_in_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  // An accepted transaction keeps the block busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("ready right after an accepted transaction");

  // The arithmetic unit is only started when it is free.
  a_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_rsp.busy)
    else $error("arithmetic unit started while busy");

endmodule

[design/nbge_alu.sv]
// Shared iterative unit: 64x64 multiply, 96/64 divide and integer square root.
`timescale 1ns / 1ps
module nbge_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  nbge_pkg::alu_req_t req,
  output nbge_pkg::alu_rsp_t rsp
);
  import nbge_pkg::*;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_SQRT
  } alu_state_t;

  localparam logic [6:0] MUL_LAST  = 7'd3;
  localparam logic [6:0] DIV_LAST  = 7'd95;
  localparam logic [6:0] SQRT_LAST = 7'd33;

  alu_state_t   st_r;
  logic [6:0]   cnt_r;
  logic         done_r;
  logic [127:0] acc_r;
  logic [95:0]  n_r;
  logic [63:0]  rem_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  trial;
  logic [64:0]  diff;
  logic         ge;
  logic [37:0]  sq_trial;
  logic [37:0]  sq_test;
  logic [37:0]  sq_diff;
  logic         sq_ge;

  // One 32x32 partial product per cycle, placed by the step count.
  always_comb begin
    a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp     = a_half * b_half;
    case (cnt_r[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_r, n_r[95]};
  assign ge    = trial >= {1'b0, b_r};
  assign diff  = trial - {1'b0, b_r};

  // Digit-by-digit square root, one result bit per cycle.
  assign sq_trial = {rem_r[35:0], n_r[95:94]};
  assign sq_test  = {2'b00, acc_r[33:0], 2'b01};
  assign sq_ge    = sq_trial >= sq_test;
  assign sq_diff  = sq_trial - sq_test;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        A_IDLE: begin
          if (req.start) begin
            cnt_r <= '0;
            a_r   <= req.a[63:0];
            b_r   <= req.b;
            acc_r <= '0;
            rem_r <= '0;
            unique case (req.op)
              ALU_MUL: begin
                st_r <= A_MUL;
              end
              ALU_DIV: begin
                n_r  <= req.a;
                st_r <= A_DIV;
              end
              ALU_SQRT: begin
                n_r  <= {req.a[67:0], 28'd0};
                st_r <= A_SQRT;
              end
              default: st_r <= A_IDLE;
            endcase
          end
        end
        A_MUL: begin
          acc_r <= acc_r + pp_sh;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == MUL_LAST) begin
            done_r <= 1'b1;
            st_r   <= A_IDLE;
          end
        end
        A_DIV: begin
          rem_r <= ge ? diff[63:0] : trial[63:0];
          n_r   <= {n_r[94:0], ge};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == DIV_LAST) begin
            acc_r  <= {32'd0, n_r[94:0], ge};
            done_r <= 1'b1;
            st_r   <= A_IDLE;
          end
        end
        A_SQRT: begin
          rem_r <= {28'd0, (sq_ge ? sq_diff[35:0] : sq_trial[35:0])};
          acc_r <= {acc_r[126:0], sq_ge};
          n_r   <= {n_r[93:0], 2'b00};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == SQRT_LAST) begin
            done_r <= 1'b1;
            st_r   <= A_IDLE;
          end
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

  assign rsp.busy = (st_r != A_IDLE);
  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

[tb/sv/nbody_gravity_euler_step_unit_test.sv]
// Testbench: directed and random check of the N-body Euler step unit against its own predictor.
`timescale 1ns / 1ps
module nbody_gravity_euler_step_unit_test;
  import nbge_pkg::*;

  localparam int          TABLE_DEPTH = 16;
  localparam int          SETTLE      = 2000;   // idle cycles before a register write
  localparam int          UNIT        = 65536;  // 1.0 in Q16.16
  localparam logic [63:0] ACC_CAP     = 64'h2000_0000_0000_0000;
  localparam logic [63:0] STEP_CAP    = 64'h0000_0100_0000_0000;

  // One stimulus row. Rows with check set carry a hand-written position for a
  // tick that reports exactly one body.
  typedef struct {
    logic               op;
    logic signed [31:0] x, y, vx, vy;
    logic [23:0]        r;
    logic               check;
    logic signed [31:0] ex, ey;
  } stim_t;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] x, y;
    logic               last;
  } body_pos_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  nbge_in_if  in_ch ();
  nbge_out_if out_ch ();

  nbody_gravity_euler_step_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the body table and of the configuration registers.
  logic signed [31:0] sh_px [TABLE_DEPTH];
  logic signed [31:0] sh_py [TABLE_DEPTH];
  logic signed [31:0] sh_vx [TABLE_DEPTH];
  logic signed [31:0] sh_vy [TABLE_DEPTH];
  logic [23:0]        sh_rad[TABLE_DEPTH];
  logic [47:0]        sh_mass[TABLE_DEPTH];
  int                 sh_count;
  logic [31:0]        sh_grav, sh_dt;
  logic [15:0]        sh_aw, sh_ah;

  body_pos_t pending_pos[$];  // positions still owed by the block
  stim_t     rows[$];
  int        errors, n_items, n_ticks, n_results;
  bit        steady;          // when set, neither side idles

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 35);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor arithmetic. Every product and quotient truncates its magnitude.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] cap_to(logic [127:0] v, logic [63:0] lim);
    return (v > 128'(lim)) ? lim : v[63:0];
  endfunction

  // Exact floor of the square root, bit by bit over 34 result bits.
  function automatic logic [127:0] floor_sqrt(logic [127:0] v);
    logic [127:0] root, trial;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic longint clamp_accel(longint v);
    if (v > longint'(ACC_CAP)) return longint'(ACC_CAP);
    if (v < -longint'(ACC_CAP)) return -longint'(ACC_CAP);
    return v;
  endfunction

  // value + sign(mult) * min((|mult| * dt) >> 16, 2^40), saturated to 32 bits.
  function automatic logic signed [31:0] euler_step(logic signed [31:0] value, longint mult);
    logic [127:0] magn;
    longint       t, sum;
    magn = (mult < 0) ? 128'(-mult) : 128'(mult);
    t    = longint'(cap_to((magn * 128'(sh_dt)) >> 16, STEP_CAP));
    sum  = longint'(value) + ((mult < 0) ? -t : t);
    if (sum > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  function automatic bool_outside(int i);
    longint r, x, y;
    r = longint'(sh_rad[i]);
    x = longint'(sh_px[i]);
    y = longint'(sh_py[i]);
    return x > (longint'(sh_aw) << 16) + r || x < -r ||
           y > (longint'(sh_ah) << 16) + r || y < -r;
  endfunction

  function automatic void drop_body(int k);
    for (int j = k + 1; j < sh_count; j++) begin
      sh_px[j-1]   = sh_px[j];
      sh_py[j-1]   = sh_py[j];
      sh_vx[j-1]   = sh_vx[j];
      sh_vy[j-1]   = sh_vy[j];
      sh_rad[j-1]  = sh_rad[j];
      sh_mass[j-1] = sh_mass[j];
    end
    if (sh_count > 0) sh_count--;
  endfunction

  // Sum of pull from every other non-overlapping body, using the table as it
  // stands, so bodies earlier in the tick contribute their new positions.
  function automatic void gravity_pull(int i, output longint ax, output longint ay);
    longint       dx, dy;
    logic [127:0] ux, uy, d, num;
    logic [63:0]  f, tx, ty;
    ax = 0;
    ay = 0;
    for (int j = 0; j < sh_count; j++) begin
      if (j == i) continue;
      dx = longint'(sh_px[j]) - longint'(sh_px[i]);
      dy = longint'(sh_py[j]) - longint'(sh_py[i]);
      ux = (dx < 0) ? 128'(-dx) : 128'(dx);
      uy = (dy < 0) ? 128'(-dy) : 128'(dy);
      d  = floor_sqrt(ux * ux + uy * uy);
      if (d == 0 || d < 128'(sh_rad[i]) + 128'(sh_rad[j])) continue;
      num = (128'(sh_grav) * 128'(sh_mass[j])) << 16;
      f   = cap_to(num / d / d, ACC_CAP);
      tx  = cap_to((128'(f) * ux) / d, ACC_CAP);
      ty  = cap_to((128'(f) * uy) / d, ACC_CAP);
      ax  = clamp_accel(ax + ((dx < 0) ? -longint'(tx) : longint'(tx)));
      ay  = clamp_accel(ay + ((dy < 0) ? -longint'(ty) : longint'(ty)));
    end
  endfunction

  // Applies one accepted transaction to the shadow table and queues the
  // positions that a tick reports.
  function automatic void predict_transaction(stim_t s);
    logic [63:0] sq;
    longint      ax, ay;
    int          i;
    body_pos_t   p;
    if (s.op == OP_INSERT) begin
      if (sh_count >= TABLE_DEPTH) drop_body(0);
      i          = sh_count;
      sq         = (64'(s.r) * 64'(s.r)) >> 16;
      sh_px[i]   = s.x;
      sh_py[i]   = s.y;
      sh_vx[i]   = s.vx;
      sh_vy[i]   = s.vy;
      sh_rad[i]  = s.r;
      sh_mass[i] = 48'((sq * 64'(PI_Q16)) >> 16);
      sh_count++;
      return;
    end
    n_ticks++;
    i = 0;
    while (i < sh_count) begin
      if (bool_outside(i)) begin
        drop_body(i);
        continue;
      end
      gravity_pull(i, ax, ay);
      sh_vx[i] = euler_step(sh_vx[i], ax);
      sh_vy[i] = euler_step(sh_vy[i], ay);
      sh_px[i] = euler_step(sh_px[i], longint'(sh_vx[i]));
      sh_py[i] = euler_step(sh_py[i], longint'(sh_vy[i]));
      i++;
    end
    for (int k = 0; k < sh_count; k++) begin
      p.idx  = 4'(k);
      p.x    = sh_px[k];
      p.y    = sh_py[k];
      p.last = (k + 1 == sh_count);
      pending_pos.push_back(p);
    end
    // A hand-written expectation replaces the predicted one.
    if (s.check && pending_pos.size() > 0) begin
      pending_pos[$].x = s.ex;
      pending_pos[$].y = s.ey;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic stim_t make_insert(logic signed [31:0] x, logic signed [31:0] y,
                                        logic [23:0] r, logic signed [31:0] vx,
                                        logic signed [31:0] vy);
    stim_t s;
    s = '{op: OP_INSERT, x: x, y: y, r: r, vx: vx, vy: vy, check: 1'b0, ex: 0, ey: 0};
    return s;
  endfunction

  function automatic stim_t make_tick();
    stim_t s;
    s = make_insert($urandom, $urandom, 24'($urandom), $urandom, $urandom);
    s.op = OP_TICK;
    return s;
  endfunction

  // Random transaction. The table is kept small so that ticks stay short;
  // most new bodies start inside the area with modest speed, some are noise.
  function automatic stim_t random_item();
    int span_x, span_y;
    if (sh_count >= 4 || $urandom_range(0, 99) < 40) return make_tick();
    if ($urandom_range(0, 99) < 15)
      return make_insert($urandom, $urandom, 24'($urandom), $urandom, $urandom);
    span_x = (sh_aw > 32767) ? 32767 : sh_aw;
    span_y = (sh_ah > 32767) ? 32767 : sh_ah;
    return make_insert(($urandom_range(0, span_x) << 16) | $urandom_range(0, UNIT - 1),
                       ($urandom_range(0, span_y) << 16) | $urandom_range(0, UNIT - 1),
                       24'($urandom_range(0, 8 * UNIT)),
                       $signed($urandom_range(0, 40 * UNIT)) - 20 * UNIT,
                       $signed($urandom_range(0, 40 * UNIT)) - 20 * UNIT);
  endfunction

  // Offers one transaction and returns at the edge where it is taken. The
  // valid line stays high between back-to-back transactions.
  task automatic send_transaction(stim_t s);
    if (take_gap()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (take_gap()) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= s.op;
    in_ch.pos_x_in  <= s.x;
    in_ch.pos_y_in  <= s.y;
    in_ch.radius_in <= s.r;
    in_ch.vel_x_in  <= s.vx;
    in_ch.vel_y_in  <= s.vy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_transaction(s);
    n_items++;
  endtask

  // Waits until every expected position has come back, then lets the block
  // finish any tick that reports nothing.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] g, logic [31:0] dt, logic [15:0] w,
                              logic [15:0] h);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [CFG_W-1:0]     val[4];
    idx = '{CFG_GRAVITY, CFG_TIME_STEP, CFG_AREA_W, CFG_AREA_H};
    val = '{g, dt, 32'(w), 32'(h)};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    sh_grav  = g;
    sh_dt    = dt;
    sh_aw    = w;
    sh_ah    = h;
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) send_transaction(random_item());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and field-by-field comparison.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    body_pos_t want;
    out_ch.ready <= rst_n ? !take_gap() : 1'b0;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_pos.size() == 0) begin
        $error("unexpected result transaction: slot %0d", out_ch.body_index);
        errors++;
      end else begin
        want = pending_pos.pop_front();
        if (out_ch.body_index !== want.idx) begin
          $error("body_index: expected %0d, got %0d", want.idx, out_ch.body_index);
          errors++;
        end
        if (out_ch.pos_x_out !== want.x) begin
          $error("pos_x_out: expected %0h, got %0h", want.x, out_ch.pos_x_out);
          errors++;
        end
        if (out_ch.pos_y_out !== want.y) begin
          $error("pos_y_out: expected %0h, got %0h", want.y, out_ch.pos_y_out);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, a directed table, then three random phases under
  // different register settings, the extremes among them.
  // ---------------------------------------------------------------------------
  initial begin
    stim_t t;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_INSERT;
    in_ch.pos_x_in  = '0;
    in_ch.pos_y_in  = '0;
    in_ch.radius_in = '0;
    in_ch.vel_x_in  = '0;
    in_ch.vel_y_in  = '0;
    errors = 0; n_items = 0; n_ticks = 0; n_results = 0;
    steady   = 1'b0;
    sh_count = 0;
    sh_grav  = GRAVITY_RST;
    sh_dt    = TIME_STEP_RST;
    sh_aw    = AREA_W_RST;
    sh_ah    = AREA_H_RST;

    // A tick on the empty table reports nothing.
    rows.push_back(make_tick());
    // A lone body at rest feels no pull and keeps its place.
    rows.push_back(make_insert(100 * UNIT, 100 * UNIT, 24'(UNIT), 0, 0));
    t = make_tick();
    t.check = 1'b1;
    t.ex    = 100 * UNIT;
    t.ey    = 100 * UNIT;
    rows.push_back(t);
    // Extreme fields: both of these lie outside the area and are removed.
    rows.push_back(make_insert(32'sh7FFFFFFF, 0, 24'hFFFFFF, 0, 0));
    rows.push_back(make_insert(32'sh80000000, 32'sh80000000, 24'd0,
                               32'sh7FFFFFFF, 32'sh80000000));
    // A massless body at full speed sharing its spot with another (zero
    // distance), and a third that overlaps the second.
    rows.push_back(make_insert(200 * UNIT, 200 * UNIT, 24'd0, 32'sh7FFFFFFF, 32'sh80000000));
    rows.push_back(make_insert(200 * UNIT, 200 * UNIT, 24'(2 * UNIT), 0, 0));
    rows.push_back(make_insert(203 * UNIT, 200 * UNIT, 24'(2 * UNIT), UNIT, -UNIT));
    // Fill the table past its depth so the oldest body is evicted.
    for (int k = 0; k < 11; k++)
      rows.push_back(make_insert((300 + 37 * k) * UNIT, (150 + 23 * k) * UNIT,
                                 24'(k * UNIT / 2), (k - 5) * UNIT, (5 - k) * 4096));
    rows.push_back(make_tick());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) send_transaction(rows[k]);
    drain();

    // Strongest gravity, frozen time, smallest area: the old bodies drop out.
    write_config(32'hFFFFFFFF, 32'd0, 16'd1, 16'd1);
    random_phase(34);

    // No gravity, the longest step and the largest area.
    write_config(32'd0, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(33);

    // Moderate random settings, starting with a stretch without idling.
    write_config($urandom, $urandom_range(256, 4096), 16'($urandom_range(100, 2000)),
                 16'($urandom_range(100, 2000)));
    steady = 1'b1;
    for (int k = 0; k < 15; k++) send_transaction(random_item());
    steady = 1'b0;
    random_phase(18);

    $display("Sent %0d transactions (%0d ticks) under four register settings,", n_items,
             n_ticks);
    $display("and compared %0d reported body positions.", n_results);
    if (errors == 0) begin
      $display("nbody_gravity_euler_step_unit: match");
    end else begin
      $display("nbody_gravity_euler_step_unit: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50_000_000;
    $display("nbody_gravity_euler_step_unit: mismatch");
    $finish;
  end

endmodule
